FILE: hdl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiplier
// Opcodes, field widths, default sizes and the tag and result records that
// travel from the sequencer through the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mm_pkg;

  // default sizes
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 16;

  // fixed port field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int ELEM_W  = 16;
  localparam int VALUE_W = 35;
  localparam int CFG_W   = 4;
  localparam int REG_W   = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_RUN        = 2'd2
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_ROWS_LEFT  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_RIGHT = 2'd2
  } reg_t;

  // per-read tag carried alongside the operand pair
  typedef struct packed {
    logic             first;  // first term of a dot product
    logic             last;   // last term, sum is complete
    logic             zero;   // empty inner dimension, term counts as zero
    logic             fin;    // final element of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  // finished product element
  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               fin;
  } res_t;

endpackage

FILE: hdl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point general matrix multiply
// Loads left and right matrix elements one request at a time into two
// synchronous stores; a run request streams out every product element in
// row-major order, each the exact dot product of a left row and right column.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in_     | slave     | in_tvalid/in_tready | op, row_index, col_index,
//           |           |                     | element_value
//   out_    | master    | out_tvalid/tready   | out_row, out_col, out_value,
//           |           |                     | out_last on out_tlast
//   cfg_    | slave     | cfg_valid/cfg_ready | register index, 4-bit value
//
// A run request issues one store read pair per cycle while the pipeline
// advances, n*m*max(l,1) pairs in all (n, l, m being the clamped dims);
// the pairs pass through read, multiply and accumulate stages. No new
// request is taken until the pipeline has drained. A stalled output
// register freezes the whole pipeline. Reset clears control state only;
// store contents are undefined until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mm_pkg::IN_DATA_W-1:0]  in_tdata,   // op[1:0], row_index[4:2],
                                                    // col_index[7:5],
                                                    // element_value[23:8]
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mm_pkg::OUT_DATA_W-1:0] out_tdata,  // out_row[2:0], out_col[5:3],
                                                    // out_value[40:6], zeros
  output logic                          out_tlast,  // out_last
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mm_pkg::REG_W-1:0]      cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PAD_W  = OUT_DATA_W - (2 * IDX_W + VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  // request fields
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [ELEM_W-1:0] in_value;
  logic              in_fire;

  assign in_op    = in_tdata[1:0];
  assign in_row   = in_tdata[4:2];
  assign in_col   = in_tdata[7:5];
  assign in_value = in_tdata[23:8];
  assign in_fire  = in_tvalid && in_tready;

  // configuration registers, raw 4-bit values
  logic [CFG_W-1:0] rows_left_r;
  logic [CFG_W-1:0] inner_size_r;
  logic [CFG_W-1:0] cols_right_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_left_r  <= CFG_W'(8);
      inner_size_r <= CFG_W'(8);
      cols_right_r <= CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_LEFT:  rows_left_r  <= cfg_data;
        REG_INNER_SIZE: inner_size_r <= cfg_data;
        REG_COLS_RIGHT: cols_right_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // values above the store size act as the store size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (int'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

  logic [DIM_W-1:0] dim_n;
  logic [DIM_W-1:0] dim_l;
  logic [DIM_W-1:0] dim_m;

  assign dim_n = clamp_dim(rows_left_r);
  assign dim_l = clamp_dim(inner_size_r);
  assign dim_m = clamp_dim(cols_right_r);

  // store writes; indexes outside the store are dropped
  logic                  wr_ok;
  logic                  wr_left;
  logic                  wr_right;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign wr_ok    = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_left  = in_fire && wr_ok && (in_op == OP_LOAD_LEFT);
  assign wr_right = in_fire && wr_ok && (in_op == OP_LOAD_RIGHT);
  assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col));
  assign wr_data  = DATA_WIDTH'($signed(in_value));

  // run sequencer: walks i, j, k in row-major order, one read pair per cycle unless stalled
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;

  logic adv;
  logic k_last;
  logic j_last;
  logic i_last;
  logic pipe_busy;

  assign k_last = (dim_l == '0) || ((DIM_W'(k_r) + DIM_W'(1)) == dim_l);
  assign j_last = (DIM_W'(j_r) + DIM_W'(1)) == dim_m;
  assign i_last = (DIM_W'(i_r) + DIM_W'(1)) == dim_n;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_RUN) && (dim_n != '0) && (dim_m != '0)) begin
          state_nxt = ST_ISSUE;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          if (k_last) begin
            k_nxt = '0;
            if (j_last) begin
              j_nxt = '0;
              if (i_last) begin
                state_nxt = ST_IDLE;
              end else begin
                i_nxt = i_r + CNT_W'(1);
              end
            end else begin
              j_nxt = j_r + CNT_W'(1);
            end
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // requests wait while a run is issuing or terms are still in flight
  assign in_tready = (state_r == ST_IDLE) && !pipe_busy;

  // read addresses and tag for the current term
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_addr_left;
  logic [ADDR_W-1:0] rd_addr_right;
  tag_t              rd_tag;

  assign rd_valid      = (state_r == ST_ISSUE);
  assign rd_addr_left  = ADDR_W'(ADDR_W'(i_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r));
  assign rd_addr_right = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r));
  assign rd_tag.first  = (k_r == '0);
  assign rd_tag.last   = k_last;
  assign rd_tag.zero   = (dim_l == '0);
  assign rd_tag.fin    = k_last && j_last && i_last;
  assign rd_tag.row    = IDX_W'(i_r);
  assign rd_tag.col    = IDX_W'(j_r);

  logic res_valid;
  res_t res;

  mm_mac #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .wr_left       (wr_left),
    .wr_right      (wr_right),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_valid      (rd_valid),
    .rd_addr_left  (rd_addr_left),
    .rd_addr_right (rd_addr_right),
    .rd_tag        (rd_tag),
    .busy          (pipe_busy),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register; a held result stalls the pipeline behind it
  logic out_valid_r;
  res_t out_res_r;

  assign adv = !(out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.value, out_res_r.col, out_res_r.row};
  assign out_tlast  = out_res_r.fin;

endmodule

FILE: hdl/mm_mac.sv
// ----------------------------------------------------------------------------
// mm_mac: element stores and multiply-accumulate pipeline
// Holds the left and right stores, reads one operand pair per cycle unless
// stalled, registers the product and sums terms into a 35-bit total.
// ----------------------------------------------------------------------------
module mm_mac #(
  parameter int  MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int  DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF,
  localparam int DEPTH      = MAX_DIM * MAX_DIM,
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,        // pipeline moves this cycle
  // store writes
  input  logic                    wr_left,
  input  logic                    wr_right,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic [DATA_WIDTH-1:0]   wr_data,
  // operand reads
  input  logic                    rd_valid,
  input  logic [ADDR_W-1:0]       rd_addr_left,
  input  logic [ADDR_W-1:0]       rd_addr_right,
  input  mm_pkg::tag_t            rd_tag,
  // results
  output logic                    busy,
  output logic                    res_valid,
  output mm_pkg::res_t            res
);
  import mm_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0] left_mem  [DEPTH];
  logic [DATA_WIDTH-1:0] right_mem [DEPTH];

  logic                  s1_valid_r;
  tag_t                  s1_tag_r;
  logic [DATA_WIDTH-1:0] left_q_r;
  logic [DATA_WIDTH-1:0] right_q_r;

  logic                     s2_valid_r;
  tag_t                     s2_tag_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [VALUE_W-1:0] acc_r;
  logic [VALUE_W-1:0] term;
  logic [VALUE_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_addr] <= wr_data;
    end
    if (wr_right) begin
      right_mem[wr_addr] <= wr_data;
    end
  end

  // stage 1: registered store read
  always_ff @(posedge clk) begin
    if (adv && rd_valid) begin
      left_q_r  <= left_mem[rd_addr_left];
      right_q_r <= right_mem[rd_addr_right];
    end
    if (adv) begin
      s1_tag_r <= rd_tag;
    end
  end

  // stage 2: product
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r <= s1_tag_r;
      if (s1_tag_r.zero) begin
        prod_r <= '0;
      end else begin
        prod_r <= $signed(left_q_r) * $signed(right_q_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= rd_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage 3: accumulate, wraps modulo 2^35
  assign term = VALUE_W'(prod_r);
  assign sum  = (s2_tag_r.first ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      acc_r <= sum;
    end
  end

  assign res_valid = adv && s2_valid_r && s2_tag_r.last;
  assign res.row   = s2_tag_r.row;
  assign res.col   = s2_tag_r.col;
  assign res.value = sum;
  assign res.fin   = s2_tag_r.fin;

  assign busy = s1_valid_r || s2_valid_r;

endmodule
